[rtl/core/anp_pkg.sv]
// Shared types, character codes and digit decoding for the ASCII number parser.
package anp_pkg;

   localparam int MAX_CHARS_DEF = 16;
   localparam int VALUE_W       = 64;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_BIN = 2'd2
   } radix_type;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CHAR_ONE   = 8'h31;  // '1'
   localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
   localparam logic [7:0] CHAR_LO_A  = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_LO_F  = 8'h66;  // 'f'
   localparam logic [7:0] CHAR_UP_A  = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_UP_F  = 8'h46;  // 'F'
   localparam logic [7:0] CHAR_LO_X  = 8'h78;  // 'x'
   localparam logic [7:0] CHAR_UP_X  = 8'h58;  // 'X'
   localparam logic [7:0] CHAR_LO_B  = 8'h62;  // 'b'
   localparam logic [7:0] CHAR_UP_B  = 8'h42;  // 'B'
   localparam logic [7:0] HEX_LETTER_OFS = 8'd10;

   // Parse flags kept between characters
   typedef struct packed {
      radix_type radix;
      logic      lead_zero;
      logic      finished;
   } flags_type;

   // One result item
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               ok;
      radix_type          radix;
   } result_type;

   // Digit decode: bit 4 = valid, bits 3:0 = digit value
   function automatic logic [4:0] digit_of(input logic [7:0] c, input radix_type r);
      logic [4:0] d;
      logic [7:0] t;
      d = 5'd0;
      t = 8'd0;
      case (r)
         RADIX_BIN: begin
            if (c == CHAR_ZERO || c == CHAR_ONE) begin
               t = c - CHAR_ZERO;
               d = {1'b1, t[3:0]};
            end
         end
         RADIX_HEX: begin
            if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
               t = c - CHAR_ZERO;
               d = {1'b1, t[3:0]};
            end else if (c inside {[CHAR_LO_A:CHAR_LO_F]}) begin
               t = c - CHAR_LO_A + HEX_LETTER_OFS;
               d = {1'b1, t[3:0]};
            end else if (c inside {[CHAR_UP_A:CHAR_UP_F]}) begin
               t = c - CHAR_UP_A + HEX_LETTER_OFS;
               d = {1'b1, t[3:0]};
            end
         end
         RADIX_DEC: begin
            if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
               t = c - CHAR_ZERO;
               d = {1'b1, t[3:0]};
            end
         end
         default: d = 5'd0;
      endcase
      return d;
   endfunction

endpackage

[rtl/core/anp_step.sv]
// Per-character parse step: prefix detection, digit accumulate and end-of-parse decision.
module anp_step
   import anp_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEF,
   localparam int POS_W = $clog2(MAX_CHARS + 1)
) (
   input  logic [7:0]         char_code,
   input  logic               starts_string,
   input  logic [VALUE_W-1:0] accum,
   input  logic [POS_W-1:0]   position,
   input  flags_type          flags,
   output logic [VALUE_W-1:0] accum_nxt,
   output logic [POS_W-1:0]   position_nxt,
   output flags_type          flags_nxt,
   output logic               emit,
   output result_type         result
);

   logic               handled;
   logic               skip;
   logic [4:0]         dig;
   logic [VALUE_W-1:0] scaled;

   always_comb begin
      accum_nxt    = accum;
      position_nxt = position;
      flags_nxt    = flags;
      handled      = 1'b0;
      skip         = 1'b0;
      emit         = 1'b0;
      dig          = 5'd0;
      scaled       = '0;

      if (starts_string) begin
         accum_nxt           = '0;
         position_nxt        = '0;
         flags_nxt.radix     = RADIX_DEC;
         flags_nxt.lead_zero = 1'b0;
         flags_nxt.finished  = 1'b0;
         if (char_code == CHAR_ZERO) begin
            flags_nxt.lead_zero = 1'b1;
            position_nxt        = POS_W'(1);
            handled             = 1'b1;
         end
      end else if (flags.finished) begin
         skip = 1'b1;
      end else if (flags.lead_zero) begin
         flags_nxt.lead_zero = 1'b0;
         if (char_code == CHAR_LO_X || char_code == CHAR_UP_X) begin
            flags_nxt.radix = RADIX_HEX;
            position_nxt    = POS_W'(2);
            handled         = 1'b1;
         end else if (char_code == CHAR_LO_B || char_code == CHAR_UP_B) begin
            flags_nxt.radix = RADIX_BIN;
            position_nxt    = POS_W'(2);
            handled         = 1'b1;
         end
      end

      if (!skip && !handled) begin
         dig = digit_of(char_code, flags_nxt.radix);
         if (!dig[4]) begin
            emit = 1'b1;
         end else begin
            // value * base as shift and add
            case (flags_nxt.radix)
               RADIX_HEX: scaled = accum_nxt << 4;
               RADIX_BIN: scaled = accum_nxt << 1;
               RADIX_DEC: scaled = (accum_nxt << 3) + (accum_nxt << 1);
               default:   scaled = accum_nxt;
            endcase
            accum_nxt    = scaled + VALUE_W'(dig[3:0]);
            position_nxt = position_nxt + POS_W'(1);
         end
      end

      if (!skip && !emit && position_nxt >= POS_W'(MAX_CHARS)) begin
         emit = 1'b1;
      end

      if (emit) begin
         flags_nxt.finished  = 1'b1;
         flags_nxt.lead_zero = 1'b0;
      end
   end

   assign result.value = accum_nxt;
   assign result.ok    = (position_nxt != '0);
   assign result.radix = flags_nxt.radix;

endmodule

[rtl/core/anp_result_reg.sv]
// Result register with stall handling on the rsp channel.
module anp_result_reg
   import anp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  result_type         result,
   input  logic               rsp_stall,
   output logic               out_free,
   output logic               rsp_valid,
   output logic [VALUE_W-1:0] rsp_parsed_value,
   output logic               rsp_ok,
   output logic [1:0]         rsp_radix_code
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff && rsp_stall;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_parsed_value = data_ff.value;
   assign rsp_ok           = data_ff.ok;
   assign rsp_radix_code   = data_ff.radix;

`ifndef SYNTH
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free) else $error("result overwritten while stalled");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid) else $error("loaded result not presented");

   a_fail_is_dec: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_radix_code == RADIX_DEC))
      else $error("failed parse with prefix radix");

   a_fail_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ok) |-> (rsp_parsed_value == '0))
      else $error("failed parse with nonzero value");
`endif

endmodule

[rtl/core/ascii_number_parser_core.sv]
// Streaming ASCII to unsigned integer parser, top level.
// Takes one character per item on req_, starts_string marking the first character of a
// string. A leading 0x/0X selects hex, 0b/0B binary, otherwise decimal; the prefix counts
// toward the MAX_CHARS position limit. The first invalid character, or the character that
// brings the position to MAX_CHARS, ends the parse and sends one item on rsp_: the value
// (wrapping at 64 bits), ok (0 only for a decimal string with no digit) and radix_code
// (0 dec, 1 hex, 2 bin). Characters after the end are dropped until the next start flag;
// a start flag mid-parse abandons the old string without a result.
// Throughput is one character per clock while req_stall is low. A character is first
// loaded into the input register; one step of shift-and-add accumulate then writes the
// parse state and, at the end of a parse, the result register, from which rsp_ takes the
// result item. The accumulate step is the only loop.
// req_stall rises only when a character that ends a parse meets a result still stalled
// on rsp_. No post-reset init sequence is needed.
module ascii_number_parser_core
   import anp_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_code,
   input  logic               req_starts_string,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_parsed_value,
   output logic               rsp_ok,
   output logic [1:0]         rsp_radix_code
);

   localparam int POS_W = $clog2(MAX_CHARS + 1);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff, in_char_in;
   logic       in_first_ff, in_first_in;

   // parse state
   logic [VALUE_W-1:0] accum_ff, accum_in;
   logic [POS_W-1:0]   position_ff, position_in;
   flags_type          flags_ff, flags_in;

   logic       emit;
   logic       out_free;
   logic       step_go;
   logic       take;
   result_type result;

   anp_step #(
      .MAX_CHARS (MAX_CHARS)
   ) u_step (
      .char_code     (in_char_ff),
      .starts_string (in_first_ff),
      .accum         (accum_ff),
      .position      (position_ff),
      .flags         (flags_ff),
      .accum_nxt     (accum_in),
      .position_nxt  (position_in),
      .flags_nxt     (flags_in),
      .emit          (emit),
      .result        (result)
   );

   // a character that ends a parse needs room in the result register
   assign step_go   = in_valid_ff && (!emit || out_free);
   assign req_stall = in_valid_ff && !step_go;
   assign take      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff && !step_go;
      in_char_in  = in_char_ff;
      in_first_in = in_first_ff;
      if (take) begin
         in_valid_in = 1'b1;
         in_char_in  = req_char_code;
         in_first_in = req_starts_string;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_char_ff  <= in_char_in;
      in_first_ff <= in_first_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff           <= '0;
         position_ff        <= '0;
         flags_ff.radix     <= RADIX_DEC;
         flags_ff.lead_zero <= 1'b0;
         flags_ff.finished  <= 1'b1;   // idle until a first character
      end else if (step_go) begin
         accum_ff    <= accum_in;
         position_ff <= position_in;
         flags_ff    <= flags_in;
      end
   end

   anp_result_reg u_result (
      .clock            (clock),
      .reset            (reset),
      .load             (step_go && emit),
      .result           (result),
      .rsp_stall        (rsp_stall),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_ok           (rsp_ok),
      .rsp_radix_code   (rsp_radix_code)
   );

`ifndef SYNTH
   a_pos_limit: assert property (@(posedge clock) disable iff (reset)
      !flags_ff.finished |-> (position_ff < POS_W'(MAX_CHARS)))
      else $error("position beyond limit while parsing");

   a_lz_pos: assert property (@(posedge clock) disable iff (reset)
      flags_ff.lead_zero |-> (position_ff == POS_W'(1) && !flags_ff.finished))
      else $error("leading zero flag out of place");

   a_fin_no_lz: assert property (@(posedge clock) disable iff (reset)
      flags_ff.finished |-> !flags_ff.lead_zero)
      else $error("leading zero flag set after parse end");
`endif

endmodule
